/* src/esc_pkg.sv */
// Shared types, register codes and helpers for the sensor compensation pipeline.
`default_nettype none
package esc_pkg;

  localparam int DIV_STAGES = 32;
  localparam logic [31:0] HUM_LIMIT = 32'd419430400;

  typedef enum logic [2:0] {
    CFG_CAL_TEMPERATURE = 3'd0,
    CFG_CAL_PRESSURE_A  = 3'd1,
    CFG_CAL_PRESSURE_B  = 3'd2,
    CFG_CAL_PRESSURE_C  = 3'd3,
    CFG_CAL_HUMIDITY_A  = 3'd4,
    CFG_CAL_HUMIDITY_B  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } reading_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
    logic               pressure_invalid;
  } result_t;

  // Calibration words, each widened to a 32-bit two's complement word.
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  // Values that ride along with the pressure division.
  typedef struct packed {
    logic [31:0] temperature;
    logic [16:0] humidity;
    logic        pre_doubled;
    logic        invalid;
  } side_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic [31:0] quotient;
    side_t       side;
  } div_out_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    logic signed [31:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/esc_front.sv */
// Temperature, pressure operand and humidity stages ahead of the divider.
`default_nettype none
module esc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire esc_pkg::reading_t in_data,
  input  wire esc_pkg::cal_t   cal,
  output logic                 out_valid,
  output esc_pkg::div_in_t     out_data
);

  logic [14:1] vld;

  logic [31:0] s1_m1, s1_m2, s2_v1, s2_m3, s3_tf, s4_t5, s4_v1p, s4_x;
  logic [31:0] s5_qq, s5_v1p5, s5_p2v1, s5_h5x, s5_xh6, s5_xh3;
  logic [31:0] s6_v2a, s6_mp3, s6_v1p5, s6_p2v1, s6_u, s6_w, s6_y;
  logic [31:0] s7_v2, s7_v1, s7_wy, s7_u;
  logic [31:0] s8_mv1, s8_pn, s8_z, s8_u;
  logic [31:0] s9_v1f, s9_pm, s9_mz, s9_u;
  logic [31:0] s10_z2, s10_u, s11_xm, s12_ms, s12_xm, s13_mh, s13_xm;
  logic [19:0] rp1, rp2, rp3, rp4, rp5, rp6, rp7;
  logic [15:0] rh1, rh2, rh3, rh4, rh5;
  logic [31:0] temp_pipe [5:14];
  logic [31:0] dvd_pipe [10:14];
  logic [31:0] dvs_pipe [10:14];
  logic        dbl_pipe [10:14];
  logic        inv_pipe [10:14];
  logic [16:0] s14_hum;

  logic [31:0] rt, a_t, d_t, q_p, x2, hum_c;

  always_comb begin
    rt  = {12'd0, in_data.raw_temperature};
    a_t = (rt >> 3) - (cal.t1 << 1);
    d_t = (rt >> 4) - cal.t1;
    q_p = esc_pkg::asr(s4_v1p, 5'd2);
    x2  = s13_xm - esc_pkg::asr(s13_mh, 5'd4);
    if (x2[31]) begin
      hum_c = 32'd0;
    end else if (x2 > esc_pkg::HUM_LIMIT) begin
      hum_c = esc_pkg::HUM_LIMIT;
    end else begin
      hum_c = x2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[13:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1 <= a_t * cal.t2;
      s1_m2 <= d_t * d_t;
      rp1 <= in_data.raw_pressure;
      rh1 <= in_data.raw_humidity;

      s2_v1 <= esc_pkg::asr(s1_m1, 5'd11);
      s2_m3 <= esc_pkg::asr(s1_m2, 5'd12) * cal.t3;
      rp2 <= rp1;
      rh2 <= rh1;

      s3_tf <= s2_v1 + esc_pkg::asr(s2_m3, 5'd14);
      rp3 <= rp2;
      rh3 <= rh2;

      s4_t5  <= s3_tf * 32'd5 + 32'd128;
      s4_v1p <= esc_pkg::asr(s3_tf, 5'd1) - 32'd64000;
      s4_x   <= s3_tf - 32'd76800;
      rp4 <= rp3;
      rh4 <= rh3;

      s5_qq   <= q_p * q_p;
      s5_v1p5 <= s4_v1p * cal.p5;
      s5_p2v1 <= cal.p2 * s4_v1p;
      s5_h5x  <= cal.h5 * s4_x;
      s5_xh6  <= s4_x * cal.h6;
      s5_xh3  <= s4_x * cal.h3;
      temp_pipe[5] <= esc_pkg::asr(s4_t5, 5'd8);
      rp5 <= rp4;
      rh5 <= rh4;

      s6_v2a  <= esc_pkg::asr(s5_qq, 5'd11) * cal.p6;
      s6_mp3  <= cal.p3 * esc_pkg::asr(s5_qq, 5'd13);
      s6_v1p5 <= s5_v1p5;
      s6_p2v1 <= s5_p2v1;
      s6_u <= esc_pkg::asr(({16'd0, rh5} << 14) - (cal.h4 << 20) - s5_h5x + 32'd16384,
                           5'd15);
      s6_w <= esc_pkg::asr(s5_xh6, 5'd10);
      s6_y <= esc_pkg::asr(s5_xh3, 5'd11) + 32'd32768;
      rp6 <= rp5;

      s7_v2 <= esc_pkg::asr(s6_v2a + (s6_v1p5 << 1), 5'd2) + (cal.p4 << 16);
      s7_v1 <= esc_pkg::asr(esc_pkg::asr(s6_mp3, 5'd3) + esc_pkg::asr(s6_p2v1, 5'd1),
                            5'd18);
      s7_wy <= s6_w * s6_y;
      s7_u  <= s6_u;
      rp7 <= rp6;

      s8_mv1 <= (32'd32768 + s7_v1) * cal.p1;
      s8_pn  <= (32'd1048576 - {12'd0, rp7}) - esc_pkg::asr(s7_v2, 5'd12);
      s8_z   <= esc_pkg::asr(s7_wy, 5'd10) + 32'd2097152;
      s8_u   <= s7_u;

      s9_v1f <= esc_pkg::asr(s8_mv1, 5'd15);
      s9_pm  <= s8_pn * 32'd3125;
      s9_mz  <= s8_z * cal.h2;
      s9_u   <= s8_u;

      dvs_pipe[10] <= s9_v1f;
      inv_pipe[10] <= (s9_v1f == 32'd0);
      dbl_pipe[10] <= ~s9_pm[31];
      dvd_pipe[10] <= s9_pm[31] ? s9_pm : (s9_pm << 1);
      s10_z2 <= esc_pkg::asr(s9_mz + 32'd8192, 5'd14);
      s10_u  <= s9_u;

      s11_xm <= s10_u * s10_z2;

      s12_ms <= esc_pkg::asr(s11_xm, 5'd15) * esc_pkg::asr(s11_xm, 5'd15);
      s12_xm <= s11_xm;

      s13_mh <= esc_pkg::asr(s12_ms, 5'd7) * cal.h1;
      s13_xm <= s12_xm;

      s14_hum <= hum_c[28:12];

      for (int i = 6; i <= 14; i++) begin
        temp_pipe[i] <= temp_pipe[i-1];
      end
      for (int i = 11; i <= 14; i++) begin
        dvd_pipe[i] <= dvd_pipe[i-1];
        dvs_pipe[i] <= dvs_pipe[i-1];
        dbl_pipe[i] <= dbl_pipe[i-1];
        inv_pipe[i] <= inv_pipe[i-1];
      end
    end
  end

  assign out_valid                 = vld[14];
  assign out_data.dividend         = dvd_pipe[14];
  assign out_data.divisor          = dvs_pipe[14];
  assign out_data.side.temperature = temp_pipe[14];
  assign out_data.side.humidity    = s14_hum;
  assign out_data.side.pre_doubled = dbl_pipe[14];
  assign out_data.side.invalid     = inv_pipe[14];

endmodule
`default_nettype wire

/* src/esc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module esc_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire esc_pkg::div_in_t in_data,
  output logic                  out_valid,
  output esc_pkg::div_out_t     out_data
);

  localparam int N = esc_pkg::DIV_STAGES;

  logic [N-1:0] vld;
  logic [31:0]  rem [N];
  logic [31:0]  num [N];
  logic [31:0]  quo [N];
  logic [31:0]  dvs [N];
  esc_pkg::side_t side [N];

  logic [31:0] src_r [N];
  logic [31:0] src_n [N];
  logic [31:0] src_q [N];
  logic [31:0] src_d [N];
  logic [32:0] sh [N];
  logic [32:0] df [N];
  logic        ge [N];

  always_comb begin
    src_r[0] = 32'd0;
    src_n[0] = in_data.dividend;
    src_q[0] = 32'd0;
    src_d[0] = in_data.divisor;
    for (int i = 1; i < N; i++) begin
      src_r[i] = rem[i-1];
      src_n[i] = num[i-1];
      src_q[i] = quo[i-1];
      src_d[i] = dvs[i-1];
    end
    for (int i = 0; i < N; i++) begin
      sh[i] = {src_r[i], src_n[i][31]};
      df[i] = sh[i] - {1'b0, src_d[i]};
      ge[i] = (sh[i] >= {1'b0, src_d[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_data.side;
      for (int i = 1; i < N; i++) begin
        side[i] <= side[i-1];
      end
      for (int i = 0; i < N; i++) begin
        rem[i] <= ge[i] ? df[i][31:0] : sh[i][31:0];
        num[i] <= src_n[i] << 1;
        quo[i] <= {src_q[i][30:0], ge[i]};
        dvs[i] <= src_d[i];
      end
    end
  end

  assign out_valid         = vld[N-1];
  assign out_data.quotient = quo[N-1];
  assign out_data.side     = side[N-1];

endmodule
`default_nettype wire

/* src/esc_back.sv */
// Pressure correction stages after the divider, ending in the result register.
`default_nettype none
module esc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire esc_pkg::div_out_t in_data,
  input  wire esc_pkg::cal_t     cal,
  output logic                   out_valid,
  output esc_pkg::result_t       out_data
);

  logic [3:1]  vld;
  logic [31:0] p0, b1_pp, b1_m8, b1_p, b2_m9, b2_m8, b2_p, pf;
  esc_pkg::side_t sd1, sd2;

  always_comb begin
    p0 = in_data.side.pre_doubled ? in_data.quotient : (in_data.quotient << 1);
    pf = b2_p + esc_pkg::asr(esc_pkg::asr(b2_m9, 5'd12) + esc_pkg::asr(b2_m8, 5'd13)
                             + cal.p7, 5'd4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_pp <= (p0 >> 3) * (p0 >> 3);
      b1_m8 <= (p0 >> 2) * cal.p8;
      b1_p  <= p0;
      sd1   <= in_data.side;

      b2_m9 <= cal.p9 * (b1_pp >> 13);
      b2_m8 <= b1_m8;
      b2_p  <= b1_p;
      sd2   <= sd1;

      out_data.temperature_centi <= sd2.temperature;
      out_data.pressure_pa       <= sd2.invalid ? 32'd0 : pf;
      out_data.humidity_q10      <= sd2.humidity;
      out_data.pressure_invalid  <= sd2.invalid;
    end
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire

/* src/env_sensor_compensation.sv */
// Depth: 49 register stages lie between an accepted reading and its result.
// Throughput: one transaction per cycle unless stalled; the front, the 32-stage divider and
// the back all advance together, so a stall at the result side holds every stage in place.
// Reset: synchronous rst clears all valid bits and sets every calibration register to zero.
`default_nettype none
module env_sensor_compensation (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              reading_valid,
  output logic                   reading_stall,
  input  wire esc_pkg::reading_t reading,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output esc_pkg::result_t       result,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [47:0]       cfg_data
);

  // Calibration registers, packed as the sensor stores its trimming words.
  logic [47:0] cal_temperature, cal_pressure_a, cal_pressure_b, cal_pressure_c;
  logic [31:0] cal_humidity_a, cal_humidity_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temperature <= '0;
      cal_pressure_a  <= '0;
      cal_pressure_b  <= '0;
      cal_pressure_c  <= '0;
      cal_humidity_a  <= '0;
      cal_humidity_b  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esc_pkg::CFG_CAL_TEMPERATURE: cal_temperature <= cfg_data;
        esc_pkg::CFG_CAL_PRESSURE_A:  cal_pressure_a  <= cfg_data;
        esc_pkg::CFG_CAL_PRESSURE_B:  cal_pressure_b  <= cfg_data;
        esc_pkg::CFG_CAL_PRESSURE_C:  cal_pressure_c  <= cfg_data;
        esc_pkg::CFG_CAL_HUMIDITY_A:  cal_humidity_a  <= cfg_data[31:0];
        esc_pkg::CFG_CAL_HUMIDITY_B:  cal_humidity_b  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack and sign- or zero-extend the calibration words once for every stage.
  esc_pkg::cal_t cal;
  always_comb begin
    cal.t1 = {16'd0, cal_temperature[15:0]};
    cal.t2 = {{16{cal_temperature[31]}}, cal_temperature[31:16]};
    cal.t3 = {{16{cal_temperature[47]}}, cal_temperature[47:32]};
    cal.p1 = {16'd0, cal_pressure_a[15:0]};
    cal.p2 = {{16{cal_pressure_a[31]}}, cal_pressure_a[31:16]};
    cal.p3 = {{16{cal_pressure_a[47]}}, cal_pressure_a[47:32]};
    cal.p4 = {{16{cal_pressure_b[15]}}, cal_pressure_b[15:0]};
    cal.p5 = {{16{cal_pressure_b[31]}}, cal_pressure_b[31:16]};
    cal.p6 = {{16{cal_pressure_b[47]}}, cal_pressure_b[47:32]};
    cal.p7 = {{16{cal_pressure_c[15]}}, cal_pressure_c[15:0]};
    cal.p8 = {{16{cal_pressure_c[31]}}, cal_pressure_c[31:16]};
    cal.p9 = {{16{cal_pressure_c[47]}}, cal_pressure_c[47:32]};
    cal.h1 = {24'd0, cal_humidity_a[7:0]};
    cal.h2 = {{16{cal_humidity_a[23]}}, cal_humidity_a[23:8]};
    cal.h3 = {24'd0, cal_humidity_a[31:24]};
    cal.h4 = {{20{cal_humidity_b[11]}}, cal_humidity_b[11:0]};
    cal.h5 = {{20{cal_humidity_b[23]}}, cal_humidity_b[23:12]};
    cal.h6 = {{24{cal_humidity_b[31]}}, cal_humidity_b[31:24]};
  end

  // The whole pipeline moves unless a finished result is being held back.
  logic en;
  assign en            = ~(result_valid & result_stall);
  assign reading_stall = ~en;

  logic             front_valid, div_valid;
  esc_pkg::div_in_t  front_data;
  esc_pkg::div_out_t div_data;

  esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (reading_valid),
    .in_data   (reading),
    .cal       (cal),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  // The pressure quotient is resolved one bit per stage.
  esc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .cal       (cal),
    .out_valid (result_valid),
    .out_data  (result)
  );

endmodule
`default_nettype wire

/* src/esc_checker.sv */
// Port-level checks for the sensor compensation block and their binding.
`default_nettype none
module esc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             reading_stall,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire esc_pkg::result_t result
);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    reading_stall == (result_valid && result_stall))
    else $error("input stalled while the output was free");

  a_invalid_zero_pressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pressure_invalid |-> result.pressure_pa == 32'd0)
    else $error("invalid pressure transaction carries nonzero pressure");

  a_humidity_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.humidity_q10 <= 17'd102400)
    else $error("humidity above the clamp limit");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
  .clk           (clk),
  .rst           (rst),
  .reading_stall (reading_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);
`default_nettype wire

/* tb/tb_env_sensor_compensation.sv */
// Regression bench for the sensor compensation pipeline, checked against its own predictor.
`default_nettype none
module tb_env_sensor_compensation;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The pipeline is 49 deep and each side may hold off between transactions.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic reading_valid = 1'b0;
  logic reading_stall;
  esc_pkg::reading_t reading = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  esc_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [47:0] cfg_data = '0;

  env_sensor_compensation u_dut (
    .clk(clk), .rst(rst),
    .reading_valid(reading_valid), .reading_stall(reading_stall), .reading(reading),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Calibration copy held by the predictor, updated alongside every register write.
  logic [47:0] cal_regs [0:5];

  esc_pkg::reading_t pending_readings [$];
  esc_pkg::result_t  expected_results [$];
  bit       failed = 1'b0;
  int       idle_cycles = 0;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sar(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // Compensates one set of raw readings with the current calibration.
  // All arithmetic is held in 32-bit words so that it wraps exactly as the hardware does.
  function automatic esc_pkg::result_t compensate(input esc_pkg::reading_t rd);
    esc_pkg::result_t r;
    logic [31:0] rt, rp, rh, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, v2, d, tf, q, p, x, u, w, y, z;
    rt = {12'd0, rd.raw_temperature};
    rp = {12'd0, rd.raw_pressure};
    rh = {16'd0, rd.raw_humidity};
    t1 = {16'd0, cal_regs[esc_pkg::CFG_CAL_TEMPERATURE][15:0]};
    t2 = sx16(cal_regs[esc_pkg::CFG_CAL_TEMPERATURE][31:16]);
    t3 = sx16(cal_regs[esc_pkg::CFG_CAL_TEMPERATURE][47:32]);
    p1 = {16'd0, cal_regs[esc_pkg::CFG_CAL_PRESSURE_A][15:0]};
    p2 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_A][31:16]);
    p3 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_A][47:32]);
    p4 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_B][15:0]);
    p5 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_B][31:16]);
    p6 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_B][47:32]);
    p7 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_C][15:0]);
    p8 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_C][31:16]);
    p9 = sx16(cal_regs[esc_pkg::CFG_CAL_PRESSURE_C][47:32]);
    h1 = {24'd0, cal_regs[esc_pkg::CFG_CAL_HUMIDITY_A][7:0]};
    h2 = sx16(cal_regs[esc_pkg::CFG_CAL_HUMIDITY_A][23:8]);
    h3 = {24'd0, cal_regs[esc_pkg::CFG_CAL_HUMIDITY_A][31:24]};
    h4 = {{20{cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][11]}},
          cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][11:0]};
    h5 = {{20{cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][23]}},
          cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][23:12]};
    h6 = {{24{cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][31]}},
          cal_regs[esc_pkg::CFG_CAL_HUMIDITY_B][31:24]};

    // Fine temperature feeds both other channels.
    v1 = sar(((rt >> 3) - (t1 << 1)) * t2, 11);
    d  = (rt >> 4) - t1;
    v2 = sar(sar(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temperature_centi = sar(tf * 32'd5 + 32'd128, 8);

    v1 = sar(tf, 1) - 32'd64000;
    q  = sar(v1, 2);
    v2 = sar(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sar(v2, 2) + (p4 << 16);
    v1 = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * v1, 1), 18);
    v1 = sar((32'd32768 + v1) * p1, 15);
    if (v1 == 32'd0) begin
      // A zero divisor forces pressure to zero and raises the flag.
      p = 32'd0;
      r.pressure_invalid = 1'b1;
    end else begin
      p = ((32'd1048576 - rp) - sar(v2, 12)) * 32'd3125;
      if (p < 32'h80000000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      v1 = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      v2 = sar((p >> 2) * p8, 13);
      p = p + sar(v1 + v2 + p7, 4);
      r.pressure_invalid = 1'b0;
    end
    r.pressure_pa = p;

    x = tf - 32'd76800;
    u = sar(((rh << 14) - (h4 << 20) - h5 * x) + 32'd16384, 15);
    w = sar(x * h6, 10);
    y = sar(x * h3, 11) + 32'd32768;
    z = sar(w * y, 10) + 32'd2097152;
    z = sar(z * h2 + 32'd8192, 14);
    x = u * z;
    x = x - sar(sar(sar(x, 15) * sar(x, 15), 7) * h1, 4);
    // Humidity is clamped to 0..100 %RH before scaling down.
    if (x[31]) x = 32'd0;
    else if (x > esc_pkg::HUM_LIMIT) x = esc_pkg::HUM_LIMIT;
    r.humidity_q10 = x[28:12];
    return r;
  endfunction

  // Driver: presents queued readings with a random hold-off between transactions.
  // The valid line is only touched once per edge, so back-to-back items keep it high.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (reading_valid && !reading_stall) begin
        expected_results.push_back(compensate(reading));
        void'(pending_readings.pop_front());
        send_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
        if (send_gap == 0 && pending_readings.size() > 0) begin
          reading <= pending_readings[0];
        end else begin
          reading_valid <= 1'b0;
        end
      end else if (!reading_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_readings.size() > 0) begin
          reading_valid <= 1'b1;
          reading <= pending_readings[0];
        end
      end
    end
  end

  // Monitor: checks each delivered result against the oldest prediction and
  // drives the result stall with random stretches.
  int stall_left = 0;
  always @(posedge clk) begin
    esc_pkg::result_t exp_r;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %h", result);
          failed = 1'b1;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.temperature_centi !== exp_r.temperature_centi) begin
            $error("temperature_centi expected %0d got %0d",
                   exp_r.temperature_centi, result.temperature_centi);
            failed = 1'b1;
          end
          if (result.pressure_pa !== exp_r.pressure_pa) begin
            $error("pressure_pa expected %0d got %0d", exp_r.pressure_pa, result.pressure_pa);
            failed = 1'b1;
          end
          if (result.humidity_q10 !== exp_r.humidity_q10) begin
            $error("humidity_q10 expected %0d got %0d",
                   exp_r.humidity_q10, result.humidity_q10);
            failed = 1'b1;
          end
          if (result.pressure_invalid !== exp_r.pressure_invalid) begin
            $error("pressure_invalid expected %0b got %0b",
                   exp_r.pressure_invalid, result.pressure_invalid);
            failed = 1'b1;
          end
        end
        stall_left = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts edges with no transaction on either channel while work is pending.
  always @(posedge clk) begin
    if (!rst) begin
      if ((reading_valid && !reading_stall) || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else if (pending_readings.size() > 0 || expected_results.size() > 0) begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("env_sensor_compensation regression: fail");
        $finish;
      end
    end
  end

  // Writes one register at an edge and mirrors it into the predictor copy.
  task automatic write_cal(input esc_pkg::cfg_idx_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cal_regs[idx] = (idx >= esc_pkg::CFG_CAL_HUMIDITY_A) ? {16'd0, val[31:0]} : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued reading has been delivered and checked, then lets the
  // pipeline settle so that a new calibration cannot touch an item in flight.
  task automatic drain;
    while (pending_readings.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Typical datasheet-like calibration with small random spread, so that most
  // readings land in the physically meaningful region of the formulas.
  task automatic load_typical;
    write_cal(esc_pkg::CFG_CAL_TEMPERATURE,
              {16'd50, 16'd26435, 16'(27504 + $urandom_range(0, 2000))});
    write_cal(esc_pkg::CFG_CAL_PRESSURE_A,
              {16'hD0D0, 16'hD67C, 16'(36477 + $urandom_range(0, 2000))});
    write_cal(esc_pkg::CFG_CAL_PRESSURE_B, {16'hFFF9, 16'h008C, 16'd2855});
    write_cal(esc_pkg::CFG_CAL_PRESSURE_C, {16'd6000, 16'hC6CE, 16'd15500});
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_B, {16'h0000, 8'd30, 12'd50, 12'd339});
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_A, {16'd0, 8'd0, 16'd361, 8'd75});
  endtask

  task automatic queue_random(input int count);
    esc_pkg::reading_t rd;
    for (int k = 0; k < count; k++) begin
      rd.raw_temperature = 20'($urandom);
      rd.raw_pressure    = 20'($urandom);
      rd.raw_humidity    = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        // Around room conditions, where the clamps and the divider are exercised
        // with ordinary values.
        rd.raw_temperature = 20'($urandom_range(400000, 600000));
        rd.raw_pressure    = 20'($urandom_range(250000, 450000));
        rd.raw_humidity    = 16'($urandom_range(20000, 40000));
      end
      pending_readings.push_back(rd);
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) cal_regs[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // With all calibration at zero the pressure divisor is zero.
    pending_readings.push_back('{20'd0, 20'd0, 16'd0});
    pending_readings.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    drain();

    // Directed corners on a typical calibration: field extremes, humidity clamps.
    load_typical();
    pending_readings.push_back('{20'd0, 20'd0, 16'd0});
    pending_readings.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    pending_readings.push_back('{20'd519888, 20'd415148, 16'd0});
    pending_readings.push_back('{20'd519888, 20'd415148, 16'hFFFF});
    pending_readings.push_back('{20'd519888, 20'd415148, 16'd30000});
    pending_readings.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
    pending_readings.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA});
    pending_readings.push_back('{20'd0, 20'hFFFFF, 16'd65535});
    drain();

    // Register extremes: all ones, then the sign boundaries of every word.
    write_cal(esc_pkg::CFG_CAL_TEMPERATURE, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_A, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_B, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_C, 48'hFFFF_FFFF_FFFF);
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_A, 48'hFFFF_FFFF);
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_B, 48'hFFFF_FFFF);
    queue_random(6);
    drain();
    write_cal(esc_pkg::CFG_CAL_TEMPERATURE, 48'h8000_7FFF_8000);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_A, 48'h7FFF_8000_FFFF);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_B, 48'h8000_7FFF_8000);
    write_cal(esc_pkg::CFG_CAL_PRESSURE_C, 48'h7FFF_8000_7FFF);
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_A, 48'h80_8000_FF);
    write_cal(esc_pkg::CFG_CAL_HUMIDITY_B, 48'h7F_800_7FF);
    queue_random(6);
    drain();

    // Random phases: mostly typical calibration, some fully random words.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph % 4 == 3) begin
        for (int i = 0; i < 6; i++) write_cal(esc_pkg::cfg_idx_t'(i), rand48());
      end else begin
        load_typical();
      end
      queue_random(100);
      drain();
    end

    if (!failed) begin
      $display("env_sensor_compensation regression: pass");
    end else begin
      $display("env_sensor_compensation regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
